/* rtl/core/gnd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_pkg: shared types and constants for the greedy note dispenser
// Note table, reciprocal table for division by a note value, status codes
// and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package gnd_pkg;

   // Data widths
   localparam int COUNT_BITS  = 16;
   localparam int AMOUNT_BITS = 16;
   localparam int NUM_NOTES   = 6;
   localparam int IDX_BITS    = 3;
   localparam int VALUE_BITS  = 7;

   localparam logic [IDX_BITS-1:0] LAST_NOTE = IDX_BITS'(NUM_NOTES - 1);

   // Division by a note value: q0 = (rest * RECIP) >> RECIP_SHIFT is the
   // quotient or one less; one compare and subtract corrects it.
   localparam int RECIP_SHIFT = AMOUNT_BITS + 1;
   localparam int PROD_BITS   = AMOUNT_BITS + RECIP_SHIFT;
   localparam int SV_BITS     = COUNT_BITS + VALUE_BITS;
   localparam int QV_BITS     = AMOUNT_BITS + VALUE_BITS;
   localparam int CMP_BITS    = (AMOUNT_BITS > COUNT_BITS) ? AMOUNT_BITS : COUNT_BITS;
   localparam int TAKE_BITS   = (COUNT_BITS > 15) ? COUNT_BITS : 15;

   localparam logic [VALUE_BITS-1:0] NOTE_VALUE [NUM_NOTES] = '{
      7'd100, 7'd50, 7'd20, 7'd10, 7'd5, 7'd2
   };

   localparam logic [RECIP_SHIFT-1:0] NOTE_RECIP [NUM_NOTES] = '{
      RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / 64'd100),
      RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / 64'd50),
      RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / 64'd20),
      RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / 64'd10),
      RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / 64'd5),
      RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / 64'd2)
   };

   // Request opcodes
   localparam logic OP_WITHDRAW = 1'b0;
   localparam logic OP_LOAD     = 1'b1;

   // Response status codes
   localparam logic [2:0] ST_DISPENSED   = 3'd0;
   localparam logic [2:0] ST_ZERO_AMOUNT = 3'd1;
   localparam logic [2:0] ST_BELOW_MIN   = 3'd2;
   localparam logic [2:0] ST_UNAVAILABLE = 3'd3;
   localparam logic [2:0] ST_LOAD_DONE   = 3'd4;

   // Controller to datapath
   typedef struct packed {
      logic                start;   // capture request
      logic                mul;     // reciprocal and stock*value products
      logic                step;    // resolve one note value
      logic                finish;  // commit or reject
      logic                emit;    // load response register
      logic [IDX_BITS-1:0] idx;     // current note value
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic short_req;  // load, zero or below-minimum: no greedy pass
   } dp_status_type;

endpackage

/* rtl/core/gnd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_ctrl: request sequencer
// Walks the note values largest first, through a product state and a divide
// step each, then commits and hands the result to the response register.
// ----------------------------------------------------------------------------
module gnd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  gnd_pkg::dp_status_type sts,
   output gnd_pkg::dp_cmd_type   cmd
);
   import gnd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      cmd.idx      = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               idx_in    = '0;
               state_in  = sts.short_req ? S_OUT : S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            if (idx_ff == LAST_NOTE) begin
               state_in = S_FIN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            // wait for the response register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/gnd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_datapath: stock counts, greedy divide unit and response register
// One shared reciprocal multiplier divides the remaining amount by the
// current note value; the take is the smaller of quotient and stock.
// ----------------------------------------------------------------------------
module gnd_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  gnd_pkg::dp_cmd_type    cmd,
   output gnd_pkg::dp_status_type sts,
   input  logic                   req_op,
   input  logic [15:0]            req_amount,
   input  logic [2:0]             req_note_index,
   input  logic [15:0]            req_note_count,
   output logic [2:0]             rsp_status,
   output logic [9:0]             rsp_take_100,
   output logic [10:0]            rsp_take_50,
   output logic [11:0]            rsp_take_20,
   output logic [12:0]            rsp_take_10,
   output logic [13:0]            rsp_take_5,
   output logic [14:0]            rsp_take_2
);
   import gnd_pkg::*;

   logic [COUNT_BITS-1:0]  stock_ff [NUM_NOTES];
   logic [COUNT_BITS-1:0]  take_ff  [NUM_NOTES];
   logic [AMOUNT_BITS-1:0] rest_ff;
   logic [2:0]             status_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [SV_BITS-1:0]     sv_ff;

   logic [AMOUNT_BITS-1:0] req_amt;
   logic [COUNT_BITS-1:0]  cur_stock;
   logic [VALUE_BITS-1:0]  cur_value;
   logic [AMOUNT_BITS-1:0] q0, q, rem0, rem, rest_in;
   logic [QV_BITS-1:0]     qv;
   logic [COUNT_BITS-1:0]  take_in;

   logic [2:0]             out_status_ff;
   logic [TAKE_BITS-1:0]   out_take_ff [NUM_NOTES];

   assign req_amt   = AMOUNT_BITS'(req_amount);
   assign cur_stock = stock_ff[cmd.idx];
   assign cur_value = NOTE_VALUE[cmd.idx];

   assign sts.short_req = (req_op == OP_LOAD) || (req_amt < AMOUNT_BITS'(2));

   // Quotient with one correction, then clamp to stock
   always_comb begin
      q0   = prod_ff[PROD_BITS-1:RECIP_SHIFT];
      qv   = QV_BITS'(q0) * QV_BITS'(cur_value);
      rem0 = rest_ff - AMOUNT_BITS'(qv);
      if (rem0 >= AMOUNT_BITS'(cur_value)) begin
         q   = q0 + 1'b1;
         rem = rem0 - AMOUNT_BITS'(cur_value);
      end else begin
         q   = q0;
         rem = rem0;
      end
      if (CMP_BITS'(cur_stock) < CMP_BITS'(q)) begin
         take_in = cur_stock;
         rest_in = rest_ff - AMOUNT_BITS'(sv_ff);
      end else begin
         take_in = COUNT_BITS'(q);
         rest_in = rem;
      end
   end

   // Stock counts
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_NOTES; i++) begin
            stock_ff[i] <= '0;
         end
      end else if (cmd.start && req_op == OP_LOAD) begin
         if (req_note_index < IDX_BITS'(NUM_NOTES)) begin
            stock_ff[req_note_index] <= COUNT_BITS'(req_note_count);
         end
      end else if (cmd.finish && rest_ff == '0) begin
         for (int i = 0; i < NUM_NOTES; i++) begin
            stock_ff[i] <= stock_ff[i] - take_ff[i];
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rest_ff <= req_amt;
         for (int i = 0; i < NUM_NOTES; i++) begin
            take_ff[i] <= '0;
         end
         if (req_op == OP_LOAD) begin
            status_ff <= ST_LOAD_DONE;
         end else if (req_amt == '0) begin
            status_ff <= ST_ZERO_AMOUNT;
         end else if (req_amt < AMOUNT_BITS'(2)) begin
            status_ff <= ST_BELOW_MIN;
         end else begin
            status_ff <= ST_DISPENSED;
         end
      end
      if (cmd.mul) begin
         prod_ff <= PROD_BITS'(rest_ff) * PROD_BITS'(NOTE_RECIP[cmd.idx]);
         sv_ff   <= SV_BITS'(cur_stock) * SV_BITS'(cur_value);
      end
      if (cmd.step) begin
         take_ff[cmd.idx] <= take_in;
         rest_ff          <= rest_in;
      end
      if (cmd.finish && rest_ff != '0) begin
         status_ff <= ST_UNAVAILABLE;
         for (int i = 0; i < NUM_NOTES; i++) begin
            take_ff[i] <= '0;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_status_ff <= status_ff;
         for (int i = 0; i < NUM_NOTES; i++) begin
            out_take_ff[i] <= TAKE_BITS'(take_ff[i]);
         end
      end
   end

   assign rsp_status   = out_status_ff;
   assign rsp_take_100 = out_take_ff[0][9:0];
   assign rsp_take_50  = out_take_ff[1][10:0];
   assign rsp_take_20  = out_take_ff[2][11:0];
   assign rsp_take_10  = out_take_ff[3][12:0];
   assign rsp_take_5   = out_take_ff[4][13:0];
   assign rsp_take_2   = out_take_ff[5][14:0];

endmodule

/* rtl/core/greedy_note_dispenser_top.sv */
`timescale 1ns / 1ps
// Sequence: load, zero or below-minimum request goes from capture to response
//   load; withdraw request passes a product and a divide step per note value
//   through the shared reciprocal divide unit, then commit and response load.
// Throughput: one request at a time; next request taken once the response
//   register has been loaded, even while that response waits.
// Reset: synchronous; clears all stock counts to zero and returns to idle.
// ----------------------------------------------------------------------------
// greedy_note_dispenser_top: greedy change making from limited note stock
// Joins the request sequencer and the datapath.
// ----------------------------------------------------------------------------
module greedy_note_dispenser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_amount,
   input  logic [2:0]  req_note_index,
   input  logic [15:0] req_note_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_take_100,
   output logic [10:0] rsp_take_50,
   output logic [11:0] rsp_take_20,
   output logic [12:0] rsp_take_10,
   output logic [13:0] rsp_take_5,
   output logic [14:0] rsp_take_2
);
   import gnd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   gnd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gnd_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_op         (req_op),
      .req_amount     (req_amount),
      .req_note_index (req_note_index),
      .req_note_count (req_note_count),
      .rsp_status     (rsp_status),
      .rsp_take_100   (rsp_take_100),
      .rsp_take_50    (rsp_take_50),
      .rsp_take_20    (rsp_take_20),
      .rsp_take_10    (rsp_take_10),
      .rsp_take_5     (rsp_take_5),
      .rsp_take_2     (rsp_take_2)
   );

   // Each divide step uses the products formed for the same note value
   a_step_after_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> ($past(cmd.mul) && $past(cmd.idx) == cmd.idx))
      else $error("divide step without matching product cycle");

   // Note index stays within the table while dividing
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.mul || cmd.step) |-> (cmd.idx <= LAST_NOTE))
      else $error("note index out of range");

   // Nothing dispensed means every take is zero
   a_takes_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DISPENSED) |->
         (rsp_take_100 == '0 && rsp_take_50 == '0 && rsp_take_20 == '0 &&
          rsp_take_10 == '0 && rsp_take_5 == '0 && rsp_take_2 == '0))
      else $error("takes reported on a request that dispensed nothing");

   // A dispensed request hands out at least one note
   a_takes_some: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DISPENSED) |->
         ((|rsp_take_100) || (|rsp_take_50) || (|rsp_take_20) ||
          (|rsp_take_10) || (|rsp_take_5) || (|rsp_take_2)))
      else $error("dispensed request with no notes");

endmodule
